/* sv/sha256_pkg.sv */
package sha256_pkg;

  // Initial hash value H0..H7, H0 in the lowest word
  localparam logic [7:0][31:0] IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam int unsigned NumRounds = 64;
  localparam int unsigned RoundW    = $clog2(NumRounds);

  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [5:0] LenStart  = 6'd56;
  localparam logic [5:0] BlockLast = 6'd63;

  // Stream operation codes (carried on tuser)
  localparam logic OpAbsorb = 1'b0;
  localparam logic OpFinish = 1'b1;

  // Control from the sequencer to the round unit
  typedef struct packed {
    logic init;    // copy chaining value into working variables
    logic round;   // run one compression round
    logic fold;    // add working variables into chaining value
    logic clear;   // return chaining value to the initial hash
  } core_ctl_t;

  // Control from the sequencer to the message schedule
  typedef struct packed {
    logic load;    // shift in one assembled message word
    logic step;    // shift in the next expanded schedule word
  } sched_ctl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  // Round constants
  function automatic logic [31:0] round_k(input logic [RoundW-1:0] idx);
    case (idx)
      6'd0:  round_k = 32'h428a2f98;
      6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;
      6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;
      6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;
      6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;
      6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;
      6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;
      6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;
      6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;
      6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;
      6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;
      6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;
      6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;
      6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;
      6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;
      6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;
      6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;
      6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;
      6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;
      6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;
      6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;
      6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;
      6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;
      6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;
      6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;
      6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;
      6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;
      6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;
      6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;
      6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;
      6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;
      6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;
      6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

/* sv/sha256_stream_hasher.sv */
// SHA-256 stream hasher. Each input transaction carries one message byte
// (tuser = 0) or a finish request (tuser = 1). Bytes are absorbed back to
// back, except that the 64th byte of a block also starts the compression:
// one shared round unit runs 64 rounds, one per cycle, then folds the result
// into the chaining value, and the input is not ready until that is done. A
// finish feeds the padding one byte per cycle, pausing for each compression,
// through the same path (9 to 72 bytes, one or two more compressions), then
// moves the digest into an output register and clears the hash state. The
// eight big-endian digest words, word 0 first and word 7 marked by tlast,
// drain from that register while the next message is already being absorbed;
// a second finish waits until the previous digest has gone out.
module sha256_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
  output logic        m_axis_tlast    // last_word
);
  import sha256_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPad   = 3'd1;
  localparam logic [2:0] StRound = 3'd2;
  localparam logic [2:0] StFold  = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [5:0]        bytes_q, bytes_d;
  logic [60:0]       msg_bytes_q, msg_bytes_d;
  logic [23:0]       acc_q, acc_d;
  logic [RoundW-1:0] rnd_q, rnd_d;
  logic              fin_q, fin_d;
  logic              marker_q, marker_d;
  logic              len_q, len_d;
  logic              last_blk_q, last_blk_d;

  logic [7:0][31:0]  out_words_q, out_words_d;
  logic [2:0]        out_idx_q, out_idx_d;
  logic              out_busy_q, out_busy_d;

  logic              in_xact, out_xact;
  logic              put_en;
  logic [7:0]        put_byte;
  logic              pad_len;
  logic [63:0]       msg_bits;
  logic [31:0]       sched_w;
  logic [7:0][31:0]  chain;
  core_ctl_t         core_ctl;
  sched_ctl_t        sched_ctl;

  assign in_xact  = s_axis_tvalid && s_axis_tready;
  assign out_xact = m_axis_tvalid && m_axis_tready;
  assign msg_bits = {msg_bytes_q, 3'b000};

  // Padding byte: marker, then zeros up to byte 56, then the big-endian bit length
  assign pad_len = marker_q && (len_q || (bytes_q == LenStart));

  always_comb begin
    put_en   = 1'b0;
    put_byte = s_axis_tdata;
    if (state_q == StIdle) begin
      put_en = in_xact && (s_axis_tuser == OpAbsorb);
    end else if (state_q == StPad) begin
      put_en = 1'b1;
      if (!marker_q) begin
        put_byte = PadMarker;
      end else if (pad_len) begin
        put_byte = msg_bits[{~bytes_q[2:0], 3'b000} +: 8];
      end else begin
        put_byte = 8'h00;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    bytes_d     = bytes_q;
    msg_bytes_d = msg_bytes_q;
    acc_d       = acc_q;
    rnd_d       = rnd_q;
    fin_d       = fin_q;
    marker_d    = marker_q;
    len_d       = len_q;
    last_blk_d  = last_blk_q;
    core_ctl    = '0;
    sched_ctl   = '0;

    if (put_en) begin
      acc_d          = {acc_q[15:0], put_byte};
      bytes_d        = bytes_q + 6'd1;
      sched_ctl.load = (bytes_q[1:0] == 2'b11);
      if (bytes_q == BlockLast) begin
        core_ctl.init = 1'b1;
        rnd_d         = '0;
        state_d       = StRound;
      end
    end

    case (state_q)
      StIdle: begin
        if (in_xact) begin
          if (s_axis_tuser == OpAbsorb) begin
            msg_bytes_d = msg_bytes_q + 61'd1;
          end else begin
            fin_d   = 1'b1;
            state_d = StPad;
          end
        end
      end
      StPad: begin
        if (!marker_q) begin
          marker_d = 1'b1;
        end else if (pad_len) begin
          len_d = 1'b1;
          if (bytes_q == BlockLast) begin
            last_blk_d = 1'b1;
          end
        end
      end
      StRound: begin
        core_ctl.round = 1'b1;
        sched_ctl.step = 1'b1;
        rnd_d          = rnd_q + 1'b1;
        if (rnd_q == RoundW'(NumRounds - 1)) begin
          state_d = StFold;
        end
      end
      StFold: begin
        core_ctl.fold = 1'b1;
        if (!fin_q) begin
          state_d = StIdle;
        end else if (last_blk_q) begin
          state_d = StDone;
        end else begin
          state_d = StPad;
        end
      end
      StDone: begin
        // Hand the digest to the output register and restart the hash
        if (!out_busy_q) begin
          core_ctl.clear = 1'b1;
          bytes_d        = '0;
          msg_bytes_d    = '0;
          fin_d          = 1'b0;
          marker_d       = 1'b0;
          len_d          = 1'b0;
          last_blk_d     = 1'b0;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output register: load the digest, shift one word per transaction
  always_comb begin
    out_words_d = out_words_q;
    out_idx_d   = out_idx_q;
    out_busy_d  = out_busy_q;
    if ((state_q == StDone) && !out_busy_q) begin
      out_words_d = chain;
      out_idx_d   = '0;
      out_busy_d  = 1'b1;
    end else if (out_xact) begin
      for (int i = 0; i < 7; i++) begin
        out_words_d[i] = out_words_q[i+1];
      end
      out_idx_d = out_idx_q + 3'd1;
      if (out_idx_q == 3'd7) begin
        out_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bytes_q     <= '0;
      msg_bytes_q <= '0;
      rnd_q       <= '0;
      fin_q       <= 1'b0;
      marker_q    <= 1'b0;
      len_q       <= 1'b0;
      last_blk_q  <= 1'b0;
      out_idx_q   <= '0;
      out_busy_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      bytes_q     <= bytes_d;
      msg_bytes_q <= msg_bytes_d;
      rnd_q       <= rnd_d;
      fin_q       <= fin_d;
      marker_q    <= marker_d;
      len_q       <= len_d;
      last_blk_q  <= last_blk_d;
      out_idx_q   <= out_idx_d;
      out_busy_q  <= out_busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    out_words_q <= out_words_d;
  end

  sha256_sched u_sched (
    .clk_i  (clk_i),
    .ctl_i  (sched_ctl),
    .word_i ({acc_q, put_byte}),
    .w_o    (sched_w)
  );

  sha256_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (core_ctl),
    .rnd_i   (rnd_q),
    .w_i     (sched_w),
    .chain_o (chain)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_busy_q;
  assign m_axis_tdata  = {5'b00000, out_idx_q, out_words_q[0]};
  assign m_axis_tlast  = (out_idx_q == 3'd7);

endmodule

/* sv/sha256_sched.sv */
module sha256_sched (
  input  logic                   clk_i,
  input  sha256_pkg::sched_ctl_t ctl_i,
  input  logic [31:0]            word_i,
  output logic [31:0]            w_o
);
  import sha256_pkg::*;

  // Sixteen-word window, oldest word in entry 0
  logic [15:0][31:0] win_q;
  logic [15:0][31:0] win_d;
  logic [31:0]       next_w;

  // Expand W[t+16] from the current window
  assign next_w = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];

  always_comb begin
    win_d = win_q;
    if (ctl_i.load || ctl_i.step) begin
      for (int i = 0; i < 15; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[15] = ctl_i.load ? word_i : next_w;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign w_o = win_q[0];

endmodule

/* sv/sha256_core.sv */
module sha256_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sha256_pkg::core_ctl_t         ctl_i,
  input  logic [sha256_pkg::RoundW-1:0] rnd_i,
  input  logic [31:0]                   w_i,
  output logic [7:0][31:0]              chain_o
);
  import sha256_pkg::*;

  logic [7:0][31:0] chain_q, chain_d;
  logic [7:0][31:0] v_q, v_d;
  logic [31:0]      t1, t2, ch, maj;

  // One compression round on the working variables a..h (entries 0..7)
  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1  = v_q[7] + big_sigma1(v_q[4]) + ch + round_k(rnd_i) + w_i;
  assign t2  = big_sigma0(v_q[0]) + maj;

  always_comb begin
    v_d = v_q;
    if (ctl_i.init) begin
      v_d = chain_q;
    end else if (ctl_i.round) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
    end
  end

  // Fold the block result into the chaining value, or restart it
  always_comb begin
    chain_d = chain_q;
    if (ctl_i.clear) begin
      chain_d = IV;
    end else if (ctl_i.fold) begin
      for (int i = 0; i < 8; i++) begin
        chain_d[i] = chain_q[i] + v_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= IV;
    end else begin
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  assign chain_o = chain_q;

endmodule

/* sv/sha256_stream_hasher_chk.sv */
module sha256_stream_hasher_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // Hold a stalled output transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output transaction dropped or changed while stalled");

  // tlast marks exactly the eighth word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
    else $error("tlast does not match word index");

  // Words of one digest follow without gaps, index advancing by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && (m_axis_tdata[34:32] == ($past(m_axis_tdata[34:32]) + 3'd1))))
    else $error("digest word sequence broken");

  // A digest always starts at word zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> (m_axis_tdata[34:32] == 3'd0))
    else $error("digest does not start at word zero");

endmodule

bind sha256_stream_hasher sha256_stream_hasher_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
